@@ src/hpmc_pkg.sv @@
// Shared constants, item type and vector rounding functions for the half-pel compensation unit.
package hpmc_pkg;

    localparam int MAX_BLOCK   = 16;
    localparam int SMALL_BLOCK = 8;
    localparam int BORDER_PAD  = 64;
    localparam int LINE_DEPTH  = MAX_BLOCK + 1;
    localparam int LINE_IDX_W  = $clog2(LINE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int LW_W     = 12;
    localparam int POS_W    = 11;
    localparam int VEC_W    = 9;
    localparam int HALF_W   = VEC_W - 1;
    localparam int ROWPOS_W = 13;
    localparam int STRIDE_W = LW_W + 1;
    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 5;
    localparam int SRC_W    = 23;
    localparam int DST_W    = 22;

    localparam logic [LW_W-1:0] LUMA_WIDTH_RESET = 12'd176;

    localparam logic FUNC_HEADER = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    localparam logic OUT_DESC  = 1'b0;
    localparam logic OUT_PIXEL = 1'b1;

    localparam logic [1:0] KIND_LUMA16  = 2'd0;
    localparam logic [1:0] KIND_LUMA8   = 2'd1;
    localparam logic [1:0] KIND_CHROMA1 = 2'd2;
    localparam logic [1:0] KIND_CHROMA4 = 2'd3;

    typedef struct packed {
        logic                       is_pixel;
        logic [POS_W-1:0]           block_x;
        logic [POS_W-1:0]           block_y;
        logic signed [ROWPOS_W-1:0] row_pos;
        logic signed [HALF_W-1:0]   half_x;
        logic                       chroma;
        logic [SIZE_W-1:0]          cols;
        logic [SIZE_W-1:0]          rows;
        logic                       frac_x;
        logic                       frac_y;
        logic [PIX_W-1:0]           cur;
        logic [PIX_W-1:0]           left;
        logic [PIX_W-1:0]           above;
        logic [PIX_W-1:0]           upleft;
        logic                       last;
    } hpmc_item_t;

    function automatic logic [1:0] chroma_round(input logic [3:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd14, 4'd15:     r = 2'd2;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic signed [VEC_W-1:0] chroma_single(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] h;
        h = {v[VEC_W-1], v[VEC_W-1:1]};
        if (v[1:0] == 2'b00 || h[0])
            return h;
        return h + 9'sd1;
    endfunction

    function automatic logic signed [VEC_W-1:0] chroma_sum(input logic signed [VEC_W-1:0] v);
        logic [VEC_W:0]   mag_wide;
        logic [VEC_W-1:0] mag;
        logic [5:0]       m;
        mag_wide = v[VEC_W-1] ? (10'd0 - {v[VEC_W-1], v}) : {1'b0, v};
        mag      = mag_wide[VEC_W-1:0];
        m        = {mag[8:4], 1'b0} + {4'b0, chroma_round(mag[3:0])};
        return v[VEC_W-1] ? (9'd0 - {3'b0, m}) : {3'b0, m};
    endfunction

endpackage

@@ src/hpmc_front.sv @@
// Front part: accepts items, derives the effective vector and runs the window neighbour state.
module hpmc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [10:0]                block_x,
    input  logic [10:0]                block_y,
    input  logic [1:0]                 block_kind,
    input  logic signed [8:0]          vec_x,
    input  logic signed [8:0]          vec_y,
    input  logic [7:0]                 pixel_in,
    input  logic                       q_full,
    output logic                       q_push,
    output hpmc_pkg::hpmc_item_t       q_item
);
    import hpmc_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    frac_x_reg, frac_x_next;
    logic                    frac_y_reg, frac_y_next;
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [SIZE_W-1:0]       col_reg, col_next;
    logic [SIZE_W-1:0]       row_reg, row_next;
    logic [PIX_W-1:0]        left_reg, left_next;
    logic [PIX_W-1:0]        upleft_reg, upleft_next;
    logic [PIX_W-1:0]        row_buf_reg [LINE_DEPTH];

    logic                    accept;
    logic                    header_acc;
    logic                    pixel_acc;
    logic signed [VEC_W-1:0] eff_x;
    logic signed [VEC_W-1:0] eff_y;
    logic [SIZE_W-1:0]       new_size;
    logic [SIZE_W-1:0]       cols;
    logic [SIZE_W-1:0]       rows;
    logic [SIZE_W-1:0]       col_inc;
    logic [SIZE_W-1:0]       row_inc;
    logic [PIX_W-1:0]        above;
    logic                    emit;
    logic                    is_last;

    assign in_stall   = q_full;
    assign accept     = in_valid && !in_stall;
    assign header_acc = accept && (func == FUNC_HEADER);
    assign pixel_acc  = accept && (func == FUNC_PIXEL) && busy_reg;

    always_comb
    begin
        case (block_kind)
            KIND_CHROMA1:
            begin
                eff_x = chroma_single(vec_x);
                eff_y = chroma_single(vec_y);
            end
            KIND_CHROMA4:
            begin
                eff_x = chroma_sum(vec_x);
                eff_y = chroma_sum(vec_y);
            end
            default:
            begin
                eff_x = vec_x;
                eff_y = vec_y;
            end
        endcase
    end

    assign new_size = (block_kind == KIND_LUMA16) ? SIZE_W'(MAX_BLOCK) : SIZE_W'(SMALL_BLOCK);
    assign cols     = size_reg + {{(SIZE_W-1){1'b0}}, frac_x_reg};
    assign rows     = size_reg + {{(SIZE_W-1){1'b0}}, frac_y_reg};
    assign col_inc  = col_reg + SIZE_W'(1);
    assign row_inc  = row_reg + SIZE_W'(1);
    assign above    = row_buf_reg[col_reg[LINE_IDX_W-1:0]];
    assign emit     = (row_reg != '0 || !frac_y_reg) && (col_reg != '0 || !frac_x_reg);
    assign is_last  = (row_inc == rows) && (col_inc == cols);

    always_comb
    begin
        busy_next   = busy_reg;
        frac_x_next = frac_x_reg;
        frac_y_next = frac_y_reg;
        size_next   = size_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        upleft_next = upleft_reg;
        if (header_acc)
        begin
            busy_next   = 1'b1;
            frac_x_next = eff_x[0];
            frac_y_next = eff_y[0];
            size_next   = new_size;
            col_next    = '0;
            row_next    = '0;
        end
        else if (pixel_acc)
        begin
            upleft_next = above;
            left_next   = pixel_in;
            if (col_inc >= cols)
            begin
                col_next = '0;
                row_next = row_inc;
            end
            else
            begin
                col_next = col_inc;
            end
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            frac_x_reg <= 1'b0;
            frac_y_reg <= 1'b0;
            size_reg   <= SIZE_W'(MAX_BLOCK);
            col_reg    <= '0;
            row_reg    <= '0;
            left_reg   <= '0;
            upleft_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            frac_x_reg <= frac_x_next;
            frac_y_reg <= frac_y_next;
            size_reg   <= size_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            left_reg   <= left_next;
            upleft_reg <= upleft_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_acc)
        begin
            row_buf_reg[col_reg[LINE_IDX_W-1:0]] <= pixel_in;
        end
    end

    assign q_push = header_acc || (pixel_acc && emit);

    always_comb
    begin
        q_item          = '0;
        q_item.is_pixel = func;
        q_item.block_x  = block_x;
        q_item.block_y  = block_y;
        q_item.row_pos  = $signed({2'b0, block_y})
                          + {{(ROWPOS_W-HALF_W){eff_y[VEC_W-1]}}, eff_y[VEC_W-1:1]};
        q_item.half_x   = eff_x[VEC_W-1:1];
        q_item.chroma   = block_kind[1];
        q_item.cols     = new_size + {{(SIZE_W-1){1'b0}}, eff_x[0]};
        q_item.rows     = new_size + {{(SIZE_W-1){1'b0}}, eff_y[0]};
        q_item.frac_x   = frac_x_reg;
        q_item.frac_y   = frac_y_reg;
        q_item.cur      = pixel_in;
        q_item.left     = left_reg;
        q_item.above    = above;
        q_item.upleft   = upleft_reg;
        q_item.last     = is_last;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> col_reg < cols)
        else $error("column count beyond window");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> row_reg < rows)
        else $error("row count beyond window");
    assert property (@(posedge clk) disable iff (!rst_n) (pixel_acc && is_last) |=> !busy_reg)
        else $error("block still busy after final pixel");
`endif

endmodule

@@ src/hpmc_queue.sv @@
// Short queue between the front and back parts.
module hpmc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hpmc_pkg::hpmc_item_t push_item,
    input  logic                 pop,
    output hpmc_pkg::hpmc_item_t head_item,
    output logic                 full,
    output logic                 empty
);
    import hpmc_pkg::*;

    hpmc_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ src/hpmc_back.sv @@
// Back part: computes window offsets or interpolated pixels into the output register.
module hpmc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [11:0]          luma_width,
    input  hpmc_pkg::hpmc_item_t head_item,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_kind,
    output logic signed [22:0]   src_offset,
    output logic [21:0]          dst_offset,
    output logic [4:0]           window_cols,
    output logic [4:0]           window_rows,
    output logic [7:0]           out_pixel,
    output logic                 last
);
    import hpmc_pkg::*;

    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg;
    logic [SRC_W-1:0]              src_reg;
    logic [DST_W-1:0]              dst_reg;
    logic [SIZE_W-1:0]             cols_reg;
    logic [SIZE_W-1:0]             rows_reg;
    logic [PIX_W-1:0]              pixel_reg;
    logic                          last_reg;

    logic [STRIDE_W-1:0]           luma_stride;
    logic [STRIDE_W-1:0]           stride;
    logic [LW_W-1:0]               dstride;
    logic signed [STRIDE_W+ROWPOS_W:0] src_prod;
    logic [LW_W+POS_W-1:0]         dst_prod;
    logic [SRC_W-1:0]              src_sum;
    logic [DST_W-1:0]              dst_sum;
    logic [PIX_W+1:0]              sum4;
    logic [PIX_W:0]                sum_h;
    logic [PIX_W:0]                sum_v;
    logic [PIX_W-1:0]              pix;

    assign q_pop          = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid_next = q_pop || (out_valid_reg && out_stall);

    assign luma_stride = {1'b0, luma_width} + STRIDE_W'(BORDER_PAD);
    assign stride      = head_item.chroma ? (luma_stride >> 1) : luma_stride;
    assign dstride     = head_item.chroma ? (luma_width >> 1) : luma_width;
    assign src_prod    = $signed({{(ROWPOS_W+1){1'b0}}, stride})
                         * $signed({{(STRIDE_W+1){head_item.row_pos[ROWPOS_W-1]}},
                                    head_item.row_pos});
    assign dst_prod    = {{POS_W{1'b0}}, dstride} * {{LW_W{1'b0}}, head_item.block_y};
    assign src_sum     = src_prod[SRC_W-1:0] + {{(SRC_W-POS_W){1'b0}}, head_item.block_x}
                         + {{(SRC_W-HALF_W){head_item.half_x[HALF_W-1]}}, head_item.half_x};
    assign dst_sum     = dst_prod[DST_W-1:0] + {{(DST_W-POS_W){1'b0}}, head_item.block_x};

    assign sum4  = {2'b0, head_item.upleft} + {2'b0, head_item.above}
                   + {2'b0, head_item.left} + {2'b0, head_item.cur} + 10'd2;
    assign sum_h = {1'b0, head_item.left} + {1'b0, head_item.cur} + 9'd1;
    assign sum_v = {1'b0, head_item.above} + {1'b0, head_item.cur} + 9'd1;

    always_comb
    begin
        case ({head_item.frac_x, head_item.frac_y})
            2'b11:   pix = sum4[PIX_W+1:2];
            2'b10:   pix = sum_h[PIX_W:1];
            2'b01:   pix = sum_v[PIX_W:1];
            default: pix = head_item.cur;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            if (head_item.is_pixel)
            begin
                kind_reg  <= OUT_PIXEL;
                src_reg   <= '0;
                dst_reg   <= '0;
                cols_reg  <= '0;
                rows_reg  <= '0;
                pixel_reg <= pix;
                last_reg  <= head_item.last;
            end
            else
            begin
                kind_reg  <= OUT_DESC;
                src_reg   <= src_sum;
                dst_reg   <= dst_sum;
                cols_reg  <= head_item.cols;
                rows_reg  <= head_item.rows;
                pixel_reg <= '0;
                last_reg  <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_kind    = kind_reg;
    assign src_offset  = $signed(src_reg);
    assign dst_offset  = dst_reg;
    assign window_cols = cols_reg;
    assign window_rows = rows_reg;
    assign out_pixel   = pixel_reg;
    assign last        = last_reg;

endmodule

@@ src/halfpel_motion_compensation_unit.sv @@
// Top level of the half-pel motion compensation unit: width register, front, queue and back.
// An item is registered first in the queue and then, as its result, in the back part's output register.
// Throughput: one item per cycle while out_stall is low, headers and reference pixels alike,
//   set by the front's single neighbour-register update per pixel and the one-entry-per-cycle queue.
// Window edge pixels and pixels outside a block give no result.
// Reset clears the width register to 176, the left and upper-left neighbour registers, the queue and the output valid.
module halfpel_motion_compensation_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [10:0]         block_x,
    input  logic [10:0]         block_y,
    input  logic [1:0]          block_kind,
    input  logic signed [8:0]   vec_x,
    input  logic signed [8:0]   vec_y,
    input  logic [7:0]          pixel_in,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                out_kind,
    output logic signed [22:0]  src_offset,
    output logic [21:0]         dst_offset,
    output logic [4:0]          window_cols,
    output logic [4:0]          window_rows,
    output logic [7:0]          out_pixel,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [11:0]         cfg_data
);
    import hpmc_pkg::*;

    logic [LW_W-1:0] luma_width_reg, luma_width_next;
    logic            q_full;
    logic            q_empty;
    logic            q_push;
    logic            q_pop;
    hpmc_item_t      push_item;
    hpmc_item_t      head_item;

    assign cfg_ready       = 1'b1;
    assign luma_width_next = (cfg_valid && cfg_ready) ? cfg_data : luma_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_width_reg <= LUMA_WIDTH_RESET;
        end
        else
        begin
            luma_width_reg <= luma_width_next;
        end
    end

    hpmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .block_x    (block_x),
        .block_y    (block_y),
        .block_kind (block_kind),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .pixel_in   (pixel_in),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    hpmc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    hpmc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .luma_width  (luma_width_reg),
        .head_item   (head_item),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .src_offset  (src_offset),
        .dst_offset  (dst_offset),
        .window_cols (window_cols),
        .window_rows (window_rows),
        .out_pixel   (out_pixel),
        .last        (last)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the half-pel motion compensation unit: directed and random tests.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import hpmc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_OFF     = 60;
    localparam int CHROMA_ROUND [16] = '{0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 2, 2};

    typedef struct {
        logic               kind;
        logic signed [22:0] src;
        logic [21:0]        dst;
        logic [4:0]         cols;
        logic [4:0]         rows;
        logic [7:0]         pel;
        logic               last_mark;
    } mc_output_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = FUNC_HEADER;
    logic [10:0]        block_x = '0;
    logic [10:0]        block_y = '0;
    logic [1:0]         block_kind = KIND_LUMA16;
    logic signed [8:0]  vec_x = '0;
    logic signed [8:0]  vec_y = '0;
    logic [7:0]         pixel_in = '0;
    logic               out_valid;
    logic               out_stall;
    logic               out_kind;
    logic signed [22:0] src_offset;
    logic [21:0]        dst_offset;
    logic [4:0]         window_cols;
    logic [4:0]         window_rows;
    logic [7:0]         out_pixel;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [11:0]        cfg_data = '0;

    logic               pace_stall = 1'b0;
    logic               hold_stall = 1'b0;
    int                 stall_left = 0;
    int                 hold_len = 0;
    bit                 steady = 1'b0;
    bit                 failed = 1'b0;
    int                 block_items = 0;
    int                 block_count = 0;
    int                 cycle_count = 0;

    mc_output_t         outputs_due [$];

    logic [11:0]        width_model = LUMA_WIDTH_RESET;
    logic               pel_frac_x = 1'b0;
    logic               pel_frac_y = 1'b0;
    int                 pel_size = MAX_BLOCK;
    int                 pel_col = 0;
    int                 pel_row = 0;
    logic [7:0]         line_buf [LINE_DEPTH] = '{default: 8'd0};
    logic [7:0]         left_pel = '0;
    logic [7:0]         upleft_pel = '0;
    logic               in_block = 1'b0;

    assign out_stall = pace_stall | hold_stall;

    halfpel_motion_compensation_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .block_x     (block_x),
        .block_y     (block_y),
        .block_kind  (block_kind),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .pixel_in    (pixel_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .src_offset  (src_offset),
        .dst_offset  (dst_offset),
        .window_cols (window_cols),
        .window_rows (window_rows),
        .out_pixel   (out_pixel),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int effective_vector(input logic [1:0] k, input int v);
        int h;
        int a;
        int m;
        h = v >>> 1;
        a = (v < 0) ? -v : v;
        m = CHROMA_ROUND[a % 16] + (a / 16) * 2;
        if (k == KIND_CHROMA1)
            return ((v & 3) == 0 || h[0]) ? h : h + 1;
        if (k == KIND_CHROMA4)
            return (v < 0) ? -m : m;
        return v;
    endfunction

    function automatic bit compensate(output mc_output_t res);
        int         vx;
        int         vy;
        int         bx;
        int         by;
        int         cols;
        int         rows;
        int         c;
        int         r;
        int         sum;
        longint     stride;
        longint     dstride;
        longint     src;
        longint     dst;
        logic [7:0] above;
        logic [7:0] cur;
        bit         emit;
        bit         is_last;
        res = '{kind: OUT_DESC, src: '0, dst: '0, cols: '0, rows: '0, pel: '0, last_mark: 1'b0};
        if (func == FUNC_HEADER)
        begin
            vx = effective_vector(block_kind, vec_x);
            vy = effective_vector(block_kind, vec_y);
            bx = block_x;
            by = block_y;
            stride = width_model + BORDER_PAD;
            dstride = width_model;
            if (block_kind == KIND_CHROMA1 || block_kind == KIND_CHROMA4)
            begin
                stride = stride >>> 1;
                dstride = dstride >>> 1;
            end
            pel_size = (block_kind == KIND_LUMA16) ? MAX_BLOCK : SMALL_BLOCK;
            pel_frac_x = vx[0];
            pel_frac_y = vy[0];
            src = stride * (by + (vy >>> 1)) + bx + (vx >>> 1);
            dst = dstride * by + bx;
            pel_col = 0;
            pel_row = 0;
            in_block = 1'b1;
            res.src = src[22:0];
            res.dst = dst[21:0];
            res.cols = pel_size + pel_frac_x;
            res.rows = pel_size + pel_frac_y;
            return 1'b1;
        end
        if (!in_block)
            return 1'b0;
        cols = pel_size + pel_frac_x;
        rows = pel_size + pel_frac_y;
        c = pel_col;
        r = pel_row;
        cur = pixel_in;
        above = (c < LINE_DEPTH) ? line_buf[c] : 8'd0;
        emit = (r >= pel_frac_y) && (c >= pel_frac_x);
        is_last = (r + 1 == rows) && (c + 1 == cols);
        if (pel_frac_x && pel_frac_y)
            sum = (upleft_pel + above + left_pel + cur + 2) >> 2;
        else if (pel_frac_x)
            sum = (left_pel + cur + 1) >> 1;
        else if (pel_frac_y)
            sum = (above + cur + 1) >> 1;
        else
            sum = cur;
        upleft_pel = above;
        if (c < LINE_DEPTH)
            line_buf[c] = cur;
        left_pel = cur;
        if (c + 1 >= cols)
        begin
            pel_col = 0;
            pel_row = (r + 1) & 31;
        end
        else
            pel_col = c + 1;
        if (is_last)
            in_block = 1'b0;
        if (!emit)
            return 1'b0;
        res.kind = OUT_PIXEL;
        res.pel = sum[7:0];
        res.last_mark = is_last;
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin
        mc_output_t want;
        mc_output_t made;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (outputs_due.size() == 0)
                begin
                    $error("unexpected transfer: out_kind %0d out_pixel %0d", out_kind, out_pixel);
                    failed = 1'b1;
                end
                else
                begin
                    want = outputs_due.pop_front();
                    if (out_kind !== want.kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                        failed = 1'b1;
                    end
                    if (src_offset !== want.src)
                    begin
                        $error("src_offset: expected %0d, got %0d", want.src, src_offset);
                        failed = 1'b1;
                    end
                    if (dst_offset !== want.dst)
                    begin
                        $error("dst_offset: expected %0d, got %0d", want.dst, dst_offset);
                        failed = 1'b1;
                    end
                    if (window_cols !== want.cols)
                    begin
                        $error("window_cols: expected %0d, got %0d", want.cols, window_cols);
                        failed = 1'b1;
                    end
                    if (window_rows !== want.rows)
                    begin
                        $error("window_rows: expected %0d, got %0d", want.rows, window_rows);
                        failed = 1'b1;
                    end
                    if (out_pixel !== want.pel)
                    begin
                        $error("out_pixel: expected %0d, got %0d", want.pel, out_pixel);
                        failed = 1'b1;
                    end
                    if (last !== want.last_mark)
                    begin
                        $error("last: expected %0d, got %0d", want.last_mark, last);
                        failed = 1'b1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                width_model = cfg_data;
            if (in_valid && !in_stall && compensate(made))
                outputs_due.push_back(made);
        end
    end

    always @(posedge clk)
    begin
        int n;
        if (out_valid && !out_stall)
        begin
            n = steady ? 0 : $urandom_range(0, 4);
            stall_left <= n;
            pace_stall <= (n > 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            pace_stall <= (stall_left > 1);
        end
    end

    initial
    begin
        forever
        begin
            wait (hold_len > 0);
            @(posedge clk);
            hold_stall <= 1'b1;
            repeat (hold_len) @(posedge clk);
            hold_stall <= 1'b0;
            hold_len = 0;
        end
    end

    task automatic send_item(input logic f, input logic [10:0] bx, input logic [10:0] by,
                             input logic [1:0] k, input logic signed [8:0] vx,
                             input logic signed [8:0] vy, input logic [7:0] pel);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func <= f;
        block_x <= bx;
        block_y <= by;
        block_kind <= k;
        vec_x <= vx;
        vec_y <= vy;
        pixel_in <= pel;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_header(input logic [10:0] bx, input logic [10:0] by, input logic [1:0] k,
                               input logic signed [8:0] vx, input logic signed [8:0] vy);
        send_item(FUNC_HEADER, bx, by, k, vx, vy, $urandom_range(0, 255));
    endtask

    task automatic send_pixel(input logic [7:0] pel);
        send_item(FUNC_PIXEL, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  $urandom_range(0, 3), $urandom_range(0, 511), $urandom_range(0, 511), pel);
    endtask

    task automatic send_block(input logic [1:0] k, input logic signed [8:0] vx,
                              input logic signed [8:0] vy, input bit whole);
        int size;
        int pels;
        size = (k == KIND_LUMA16) ? MAX_BLOCK : SMALL_BLOCK;
        pels = (size + (effective_vector(k, vx) & 1)) * (size + (effective_vector(k, vy) & 1));
        if (!whole)
            pels = $urandom_range(1, pels - 1);
        send_header($urandom_range(0, 2047), $urandom_range(0, 2047), k, vx, vy);
        repeat (pels) send_pixel($urandom_range(0, 255));
        block_items += pels + 1;
        block_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [11:0] w);
        wait_idle();
        cfg_data <= w;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_blocks(input int target);
        logic [1:0]        k;
        logic signed [8:0] vx;
        logic signed [8:0] vy;
        while (block_items < target)
        begin
            k = ($urandom_range(0, 15) == 0) ? KIND_LUMA16
                                              : 2'($urandom_range(KIND_LUMA8, KIND_CHROMA4));
            vx = $urandom_range(0, 511);
            vy = $urandom_range(0, 511);
            // walk luma blocks through all four half-pel phases
            if (k == KIND_LUMA16 || k == KIND_LUMA8)
            begin
                vx[0] = block_count[0];
                vy[0] = block_count[1];
            end
            send_block(k, vx, vy, $urandom_range(0, 7) != 0);
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 3)) send_pixel($urandom_range(0, 255));
        end
    endtask

    task automatic test_idle_pixels();
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel($urandom_range(0, 255));
    endtask

    task automatic test_header_extremes();
        send_header(11'd0, 11'd0, KIND_LUMA16, 9'sd0, 9'sd0);
        send_header(11'd2047, 11'd2047, KIND_LUMA16, 9'sd255, -9'sd256);
        send_header(11'd2047, 11'd0, KIND_LUMA8, -9'sd256, 9'sd255);
        send_header(11'd0, 11'd2047, KIND_LUMA8, -9'sd1, 9'sd1);
        send_header(11'd5, 11'd9, KIND_CHROMA1, -9'sd2, 9'sd2);
        send_header(11'd2047, 11'd2047, KIND_CHROMA1, -9'sd256, 9'sd255);
        send_header(11'd3, 11'd3, KIND_CHROMA1, 9'sd5, -9'sd3);
        send_header(11'd1, 11'd7, KIND_CHROMA1, 9'sd1, 9'sd4);
        send_header(11'd2047, 11'd0, KIND_CHROMA4, 9'sd255, -9'sd256);
        send_header(11'd0, 11'd2047, KIND_CHROMA4, 9'sd14, -9'sd13);
        send_header(11'd17, 11'd33, KIND_CHROMA4, 9'sd2, 9'sd16);
    endtask

    task automatic test_header_while_busy();
        send_header($urandom_range(0, 2047), $urandom_range(0, 2047), KIND_LUMA8, 9'sd1, 9'sd0);
        repeat (5) send_pixel($urandom_range(0, 255));
        send_header($urandom_range(0, 2047), $urandom_range(0, 2047), KIND_LUMA8, 9'sd0, 9'sd1);
    endtask

    task automatic test_output_hold_off();
        hold_len = HOLD_OFF;
        send_block(KIND_LUMA8, $urandom_range(0, 511), $urandom_range(0, 511), 1'b1);
    endtask

    task automatic test_width_settings();
        logic [11:0] widths [4];
        widths = '{12'd16, 12'd2048, 12'd4095, 12'($urandom_range(16, 2048))};
        for (int i = 0; i < 4; i++)
        begin
            set_width(widths[i]);
            steady = (i == 1);
            send_header(11'd2047, 11'd2047, $urandom_range(0, 3), 9'sd255, -9'sd256);
            send_header(11'd0, 11'd2047, KIND_CHROMA4, -9'sd256, 9'sd255);
            run_blocks(block_items + 50);
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_idle_pixels();
        test_header_extremes();
        test_header_while_busy();
        test_output_hold_off();
        test_width_settings();
        wait_idle();
        if (!failed && outputs_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
